// ===== rtl/core/u16u8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and helpers for the UTF-16 to UTF-8 transcoder
// Holds the status codes, the decoded-unit descriptor, the queue size and
// the UTF-8 byte encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LONE_LOW    = 2'd1,
    ST_HIGH_NO_LOW = 2'd2,
    ST_HIGH_AT_END = 2'd3
  } status_t;

  // One decoded code point (or error) waiting to be emitted as bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] leaves first
    logic [1:0]      last_idx;  // index of the final byte
    status_t         status;
  } unit_desc_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Surrogate prefixes of the top six bits
  localparam logic [5:0] HIGH_PREFIX = 6'b110110;
  localparam logic [5:0] LOW_PREFIX  = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  function automatic unit_desc_t encode_point(input logic [20:0] cp);
    unit_desc_t d;
    d = '0;
    d.status = ST_OK;
    if (cp[20:7] == '0) begin
      d.bytes[0] = cp[7:0];
      d.last_idx = 2'd0;
    end else if (cp[20:11] == '0) begin
      d.bytes[0] = {3'b110, cp[10:6]};
      d.bytes[1] = {2'b10, cp[5:0]};
      d.last_idx = 2'd1;
    end else if (cp[20:16] == '0) begin
      d.bytes[0] = {4'b1110, cp[15:12]};
      d.bytes[1] = {2'b10, cp[11:6]};
      d.bytes[2] = {2'b10, cp[5:0]};
      d.last_idx = 2'd2;
    end else begin
      d.bytes[0] = {5'b11110, cp[20:18]};
      d.bytes[1] = {2'b10, cp[17:12]};
      d.bytes[2] = {2'b10, cp[11:6]};
      d.bytes[3] = {2'b10, cp[5:0]};
      d.last_idx = 2'd3;
    end
    return d;
  endfunction

  function automatic unit_desc_t error_desc(input status_t st);
    unit_desc_t d;
    d = '0;
    d.status = st;
    return d;
  endfunction

endpackage

// ===== rtl/core/u16u8_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_if: stream channels of the transcoder
// Input channel carries UTF-16 code units, output channel carries UTF-8 bytes.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic [1:0] status;

  modport source (output valid, output out_byte, output last_of_run, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input status,
                  output ready);
endinterface

// ===== rtl/core/u16u8_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front: code unit intake and classification
// Swaps bytes if configured, tracks a pending high surrogate and pushes one
// descriptor per unit that produces output.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  u16u8_in_if.sink              in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output u16u8_pkg::unit_desc_t q_data
);
  import u16u8_pkg::*;

  logic        swap_r;
  logic        pending_r,      pending_nxt;
  logic [9:0]  pending_high_r, pending_high_nxt;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic        accept;
  logic        emit;
  logic [20:0] supp_cp;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  assign unit    = swap_r ? {in_ch.code_unit[7:0], in_ch.code_unit[15:8]} : in_ch.code_unit;
  assign is_high = (unit[15:10] == HIGH_PREFIX);
  assign is_low  = (unit[15:10] == LOW_PREFIX);
  assign supp_cp = SUPP_BASE + {1'b0, pending_high_r, unit[9:0]};

  always_comb begin
    pending_nxt      = pending_r;
    pending_high_nxt = pending_high_r;
    emit             = 1'b1;
    q_data           = encode_point({5'd0, unit});
    if (pending_r) begin
      pending_nxt      = 1'b0;
      pending_high_nxt = '0;
      if (!is_low) begin
        q_data = error_desc(ST_HIGH_NO_LOW);
      end else begin
        q_data = encode_point(supp_cp);
      end
    end else if (is_high) begin
      if (in_ch.last_unit) begin
        q_data = error_desc(ST_HIGH_AT_END);
      end else begin
        emit             = 1'b0;
        pending_nxt      = 1'b1;
        pending_high_nxt = unit[9:0];
      end
    end else if (is_low) begin
      q_data = error_desc(ST_LONE_LOW);
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r         <= 1'b0;
      pending_r      <= 1'b0;
      pending_high_r <= '0;
    end else begin
      if (cfg_we) begin
        swap_r <= cfg_wdata;
      end
      if (accept) begin
        pending_r      <= pending_nxt;
        pending_high_r <= pending_high_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/u16u8_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue: small descriptor FIFO
// Decouples the intake side from the byte emitter.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u16u8_pkg::unit_desc_t push_data,
  output logic                  full,
  input  logic                  pop,
  output u16u8_pkg::unit_desc_t pop_data,
  output logic                  empty
);
  import u16u8_pkg::*;

  unit_desc_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_CW-1:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/u16u8_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back: UTF-8 byte emitter
// Walks the bytes of one descriptor into the output register, one byte per
// cycle while out_ch is not stalled.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  u16u8_pkg::unit_desc_t q_data,
  output logic                  q_pop,
  u16u8_out_if.source           out_ch
);
  import u16u8_pkg::*;

  unit_desc_t cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  status_t    out_status_r;
  logic       load_out;
  logic       at_last;

  assign load_out = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign at_last  = (idx_r == cur_r.last_idx);
  assign q_pop    = !q_empty && (!cur_valid_r || (load_out && at_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (load_out) begin
      out_byte_r   <= cur_r.bytes[idx_r];
      out_last_r   <= at_last;
      out_status_r <= cur_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (load_out) begin
        if (at_last) begin
          cur_valid_r <= 1'b0;
          idx_r       <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.status      = out_status_r;

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder: UTF-16 code units in, UTF-8 bytes out
// Decodes surrogate pairs, flags malformed surrogate use with a single error
// byte, and optionally byte-swaps big-endian input.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  in_ch    in   valid/ready      code_unit[15:0], last_unit
//  out_ch   out  valid/ready      out_byte[7:0], last_of_run, status[1:0]
//  cfg_*    in   cfg_we strobe    cfg_wdata = swap_bytes
//
//  One output byte per cycle sustained while out_ch is ready; a code unit
//  producing n bytes (1..4) holds the emitter for all n, a paired high surrogate none.
//  Intake takes one unit per cycle while the 2-entry descriptor queue has room.
//  An input unit reaches out_ch via the descriptor queue, cur_r and the output register.
//  rst_n is synchronous, active low; it clears pending surrogate, queue and
//  swap_bytes. Either side may stall; stalls propagate through the queue.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  u16u8_in_if.sink     in_ch,
  u16u8_out_if.source  out_ch
);
  import u16u8_pkg::*;

  // Descriptor handoff between intake and emitter
  unit_desc_t push_data;
  unit_desc_t pop_data;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  // Front end: byte swap, surrogate tracking, UTF-8 encoding into a descriptor
  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  // Queue lets intake keep running while bytes drain
  u16u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Back end: serializes descriptor bytes through the output register
  u16u8_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== dv/tb_utf16_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder: self-checking bench for the UTF-16 to UTF-8
// transcoder
// A queue-fed driver pushes UTF-16 code units into the block. A predictor
// keeps its own surrogate state and byte-swap setting and builds the expected
// UTF-8 bytes at each input transaction. A monitor checks every output
// transaction against them in order. The run has a directed pass, then
// random passes with both byte orders and varied idling on each side.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES    = 8;     // settling margin after the last expected byte
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_UNITS   = 19;    // per random pass

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_START = 21'h10000;

  // One UTF-16 code unit as driven on the input channel
  typedef struct {
    logic [15:0] code_unit;
    logic        last_unit;
  } utf16_unit_t;

  // One expected UTF-8 output byte
  typedef struct {
    logic [7:0] data;
    logic       fin;
    status_t    st;
  } utf8_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  u16u8_in_if  in_ch ();
  u16u8_out_if out_ch ();

  utf16_to_utf8_transcoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  utf16_unit_t unit_q[$];        // code units waiting for the driver
  utf8_byte_t  utf8_expect_q[$]; // predicted bytes, oldest first

  // Predictor's copy of the block state
  logic        swap_cfg;
  logic        pair_open;        // a high surrogate is being held
  logic [9:0]  held_bits;        // that surrogate minus 0xD800

  int send_idle_pct;
  int recv_stall_pct;

  int error_count;
  int units_sent;
  int bytes_checked;
  int error_results;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void expect_byte(input logic [7:0] data, input logic fin,
                                      input status_t st);
    utf8_byte_t b;
    b.data = data;
    b.fin  = fin;
    b.st   = st;
    utf8_expect_q.insert(utf8_expect_q.size(), b);
  endfunction

  function automatic void expect_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      expect_byte(cp[7:0], 1'b1, ST_OK);
    end else if (cp <= 21'h7FF) begin
      expect_byte({3'b110, cp[10:6]}, 1'b0, ST_OK);
      expect_byte({2'b10, cp[5:0]}, 1'b1, ST_OK);
    end else if (cp <= 21'hFFFF) begin
      expect_byte({4'b1110, cp[15:12]}, 1'b0, ST_OK);
      expect_byte({2'b10, cp[11:6]}, 1'b0, ST_OK);
      expect_byte({2'b10, cp[5:0]}, 1'b1, ST_OK);
    end else begin
      expect_byte({5'b11110, cp[20:18]}, 1'b0, ST_OK);
      expect_byte({2'b10, cp[17:12]}, 1'b0, ST_OK);
      expect_byte({2'b10, cp[11:6]}, 1'b0, ST_OK);
      expect_byte({2'b10, cp[5:0]}, 1'b1, ST_OK);
    end
  endfunction

  // Work out the bytes caused by one accepted code unit and update state
  function automatic void transcode_unit(input logic [15:0] raw, input logic last);
    logic [15:0] u;
    logic        is_high;
    logic        is_low;
    u       = swap_cfg ? {raw[7:0], raw[15:8]} : raw;
    is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
    is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
    if (pair_open) begin
      // any unit other than a low surrogate is eaten by the error
      if (is_low) expect_code_point(SUPP_START + {1'b0, held_bits, u[9:0]});
      else expect_byte(8'h00, 1'b1, ST_HIGH_NO_LOW);
      pair_open = 1'b0;
      held_bits = '0;
    end else if (is_high) begin
      if (last) begin
        expect_byte(8'h00, 1'b1, ST_HIGH_AT_END);
      end else begin
        held_bits = u[9:0];
        pair_open = 1'b1;
      end
    end else if (is_low) begin
      expect_byte(8'h00, 1'b1, ST_LONE_LOW);
    end else begin
      expect_code_point({5'd0, u});
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one input transaction per handshake, valid held until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_blk
    logic        fire;
    utf16_unit_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        transcode_unit(in_ch.code_unit, in_ch.last_unit);
        units_sent++;
      end
      if (!in_ch.valid || fire) begin
        if (unit_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = unit_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.code_unit <= nxt.code_unit;
          in_ch.last_unit <= nxt.last_unit;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each output transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_blk
    utf8_byte_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        bytes_checked++;
        if (utf8_expect_q.size() == 0) begin
          note_error($sformatf("unexpected byte 0x%02h last=%0b status=%0d",
                               out_ch.out_byte, out_ch.last_of_run, out_ch.status));
        end else begin
          e = utf8_expect_q.pop_front();
          if (e.st != ST_OK) error_results++;
          if (out_ch.out_byte !== e.data || out_ch.last_of_run !== e.fin ||
              out_ch.status !== e.st) begin
            note_error($sformatf(
              "byte %0d mismatch: exp 0x%02h last=%0b status=%0d, got 0x%02h last=%0b status=%0d",
              bytes_checked, e.data, e.fin, e.st,
              out_ch.out_byte, out_ch.last_of_run, out_ch.status));
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Queue a code unit given in logical order; byte-swapped here when the
  // block is set for a big-endian source so the text stays well formed.
  function automatic void add_unit(input logic [15:0] u, input logic last);
    utf16_unit_t t;
    t.code_unit = swap_cfg ? {u[7:0], u[15:8]} : u;
    t.last_unit = last;
    unit_q.insert(unit_q.size(), t);
  endfunction

  // Any non-surrogate unit, spread over the 1-, 2- and 3-byte classes
  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(0, 3))
      0: begin
        return 16'($urandom_range(0, 16'h7F));
      end
      1: begin
        return 16'($urandom_range(16'h80, 16'h7FF));
      end
      2: begin
        return 16'($urandom_range(16'h800, 16'hD7FF));
      end
      default: begin
        return 16'($urandom_range(16'hE000, 16'hFFFF));
      end
    endcase
  endfunction

  // Only called while idle: the register write and the predictor copy move together
  task automatic write_swap(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    swap_cfg   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait for the queue to drain and every byte to come back. A held high
  // surrogate gives nothing back, so finish with a TAIL_CYCLES margin.
  task automatic drain();
    do @(negedge clk);
    while (unit_q.size() != 0 || in_ch.valid || utf8_expect_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_blk
    int phase;
    int kind;
    int n;
    logic [15:0] x;

    in_ch.valid     = 1'b0;
    in_ch.code_unit = '0;
    in_ch.last_unit = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    rst_n           = 1'b0;
    swap_cfg        = 1'b0;
    pair_open       = 1'b0;
    held_bits       = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    units_sent      = 0;
    bytes_checked   = 0;
    error_results   = 0;
    quiet_cycles    = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed pass: little-endian, no idling ----
    write_swap(1'b0);
    add_unit(16'h0000, 1'b0);   // 1-byte range edges
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);   // 2-byte range edges
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);   // 3-byte, around the surrogate hole
    add_unit(16'hD7FF, 1'b0);
    add_unit(16'hE000, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    add_unit(16'hD800, 1'b0);   // lowest supplementary point
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);   // highest, completing pair flagged last
    add_unit(16'hDFFF, 1'b1);
    add_unit(16'hDC00, 1'b0);   // lone lows
    add_unit(16'hDFFF, 1'b1);
    add_unit(16'hD800, 1'b0);   // high then ASCII: ASCII is eaten
    add_unit(16'h0041, 1'b0);
    add_unit(16'h1234, 1'b0);   // decodes cleanly after the error
    add_unit(16'hDBFF, 1'b0);   // high then high: second one eaten too
    add_unit(16'hD800, 1'b0);
    add_unit(16'hD800, 1'b1);   // high at end of string
    add_unit(16'hD801, 1'b0);   // pair whose low carries last
    add_unit(16'hDC01, 1'b1);
    add_unit(16'hD800, 1'b0);   // high, then a non-low that ends the string
    add_unit(16'hFFFF, 1'b1);
    drain();

    // ---- random passes: alternate byte order, vary the idling ----
    for (phase = 1; phase <= 4; phase++) begin
      write_swap(phase[0]);
      case (phase)
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      n = 0;
      while (n < RANDOM_UNITS) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          // plain BMP character
          add_unit(pick_bmp(), ($urandom_range(0, 3) == 0));
          n += 1;
        end else if (kind < 60) begin
          // well-formed surrogate pair
          add_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
          add_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), ($urandom_range(0, 3) == 0));
          n += 2;
        end else if (kind < 68) begin
          // lone low surrogate
          add_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), 1'($urandom_range(0, 1)));
          n += 1;
        end else if (kind < 78) begin
          // high followed by anything but a low
          do x = 16'($urandom);
          while (x >= LOW_FIRST && x <= LOW_LAST);
          add_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
          add_unit(x, 1'($urandom_range(0, 1)));
          n += 2;
        end else if (kind < 86) begin
          // high surrogate closing the string
          add_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b1);
          n += 1;
        end else begin
          // raw noise
          add_unit(16'($urandom), 1'($urandom_range(0, 1)));
          n += 1;
        end
      end
      drain();
    end

    if (utf8_expect_q.size() != 0)
      note_error($sformatf("%0d expected bytes never arrived", utf8_expect_q.size()));

    $display("Covered %0d code units and %0d UTF-8 bytes (%0d error results),",
             units_sent, bytes_checked, error_results);
    $display("both byte orders, sender and receiver idling 0/16/75 percent.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_if.sv
rtl/core/u16u8_front.sv
rtl/core/u16u8_queue.sv
rtl/core/u16u8_back.sv
rtl/core/utf16_to_utf8_transcoder.sv
dv/tb_utf16_to_utf8_transcoder.sv
